// ----- src/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Formats, derived widths, result kind codes and the data carried by the cells.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 32;
	localparam int IN_FRAC  = IN_W / 2;
	localparam int OUT_FRAC = OUT_W / 2;
	localparam int GUARD    = (OUT_FRAC > IN_FRAC) ? (OUT_FRAC - IN_FRAC) : 0;
	localparam int POST     = OUT_FRAC - GUARD;
	localparam int PROD_W   = 2 * IN_W;
	localparam int DM_W     = 2 * IN_W + 2;
	localparam int RAD_W    = DM_W + 2 * GUARD;
	localparam int SQ_W     = RAD_W / 2;
	localparam int BM_W     = IN_W + GUARD;
	localparam int NUM_W    = ((BM_W > SQ_W) ? BM_W : SQ_W) + 1;
	localparam int NUMS_W   = NUM_W + POST;
	localparam int DEN_W    = IN_W + 1;
	localparam int EW       = ((NUMS_W > OUT_W) ? NUMS_W : OUT_W) + 1;

	typedef enum logic [1:0] {
		KIND_TWO   = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_CPLX  = 2'd2,
		KIND_DEGEN = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              na;
		logic              nq;
		logic [BM_W-1:0]   bm;
		logic [DEN_W-1:0]  den;
		logic [RAD_W-1:0]  rad;
		logic [SQ_W:0]     rem;
		logic [SQ_W-1:0]   root;
	} sq_data_t;

	typedef struct packed {
		logic              neg;
		logic [NUMS_W-1:0] num;
		logic [DEN_W-1:0]  rem;
		logic [NUMS_W-1:0] quo;
	} dv_lane_t;

	typedef struct packed {
		kind_t            kind;
		logic [DEN_W-1:0] den;
		dv_lane_t [1:0]   lane;
	} dv_data_t;

	typedef struct packed {
		kind_t            kind;
		logic [OUT_W-1:0] first;
		logic [OUT_W-1:0] second;
		logic             sat;
	} res_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] mag;
	} sm_t;

	function automatic sm_t sm_add(logic n1, logic [NUM_W-1:0] m1,
			logic n2, logic [NUM_W-1:0] m2);
		sm_t r;
		if (n1 == n2) begin
			r.neg = n1;
			r.mag = m1 + m2;
		end else if (m1 >= m2) begin
			r.neg = n1;
			r.mag = m1 - m2;
		end else begin
			r.neg = n2;
			r.mag = m2 - m1;
		end
		return r;
	endfunction

endpackage

// ----- src/qrs_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Produces one root bit per enabled cycle and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_v,
	input  sq_data_t in_d,
	output logic     out_v,
	output sq_data_t out_d
);

	logic [SQ_W+2:0] cand;
	logic [SQ_W+2:0] trial;
	logic [SQ_W+2:0] diff;
	logic            ge;
	sq_data_t        nxt;
	logic            v_q;
	sq_data_t        d_q;

	always_comb begin
		cand  = {in_d.rem, in_d.rad[RAD_W-1 -: 2]};
		trial = {1'b0, in_d.root, 2'b01};
		ge    = cand >= trial;
		diff  = cand - trial;
		nxt      = in_d;
		nxt.rad  = in_d.rad << 2;
		nxt.rem  = ge ? diff[SQ_W:0] : cand[SQ_W:0];
		nxt.root = {in_d.root[SQ_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

// ----- src/qrs_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit per enabled cycle for both roots and passes them on.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_v,
	input  dv_data_t in_d,
	output logic     out_v,
	output dv_data_t out_d
);

	logic [DEN_W:0] cand [2];
	logic [DEN_W:0] diff [2];
	logic           ge   [2];
	dv_data_t       nxt;
	logic           v_q;
	dv_data_t       d_q;

	always_comb begin
		nxt = in_d;
		for (int l = 0; l < 2; l++) begin
			cand[l] = {in_d.lane[l].rem, in_d.lane[l].num[NUMS_W-1]};
			ge[l]   = cand[l] >= {1'b0, in_d.den};
			diff[l] = cand[l] - {1'b0, in_d.den};
			nxt.lane[l].num = in_d.lane[l].num << 1;
			nxt.lane[l].rem = ge[l] ? diff[l][DEN_W-1:0] : cand[l][DEN_W-1:0];
			nxt.lane[l].quo = {in_d.lane[l].quo[NUMS_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

// ----- src/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver
// The solver has three front stages, 25 square root cells, one numerator stage,
// 34 divider cells and the output register. One item is taken per unstalled cycle.
// Reset clears all valid bits and the skid stage; payload registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [IN_W-1:0]  coef_a,
	input  logic signed [IN_W-1:0]  coef_b,
	input  logic signed [IN_W-1:0]  coef_c,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              root_kind,
	output logic signed [OUT_W-1:0] root_first,
	output logic signed [OUT_W-1:0] root_second,
	output logic                    saturated
);

	logic              en;
	logic [IN_W-1:0]   ma_c, mb_c, mc_c;
	logic              v_s1, na_s1, nb_s1, nc_s1;
	logic [IN_W-1:0]   ma_s1, mb_s1, mc_s1;
	logic              v_s2, za_s2, same_s2, na_s2, nq_s2;
	logic [PROD_W-1:0] bb_s2, mac_s2;
	logic [BM_W-1:0]   bm_s2;
	logic [DEN_W-1:0]  den_s2;
	logic [DM_W-1:0]   four, bbx, dmag;
	logic              nd;
	sq_data_t          sq_c;
	logic              v_s3;
	sq_data_t          sq_s3;
	logic              sq_v [SQ_W+1];
	sq_data_t          sq_d [SQ_W+1];
	sm_t               r1, r2;
	dv_data_t          dv_c;
	logic              v_s4;
	dv_data_t          dv_s4;
	logic              dv_v [NUMS_W+1];
	dv_data_t          dv_d [NUMS_W+1];
	logic [EW-1:0]     qx [2];
	logic [EW-1:0]     lim [2];
	logic [EW-1:0]     qc [2];
	logic              cl [2];
	logic              p_v;
	res_t              p_d;
	logic              take;
	logic              out_v_q, skid_v_q;
	res_t              out_d_q, skid_d_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_comb begin
		ma_c = coef_a[IN_W-1] ? $unsigned(~coef_a) + 1'b1 : $unsigned(coef_a);
		mb_c = coef_b[IN_W-1] ? $unsigned(~coef_b) + 1'b1 : $unsigned(coef_b);
		mc_c = coef_c[IN_W-1] ? $unsigned(~coef_c) + 1'b1 : $unsigned(coef_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v[SQ_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s1   <= coef_a[IN_W-1];
			nb_s1   <= coef_b[IN_W-1];
			nc_s1   <= coef_c[IN_W-1];
			ma_s1   <= ma_c;
			mb_s1   <= mb_c;
			mc_s1   <= mc_c;
			bb_s2   <= PROD_W'(mb_s1) * PROD_W'(mb_s1);
			mac_s2  <= PROD_W'(ma_s1) * PROD_W'(mc_s1);
			za_s2   <= ma_s1 == '0;
			same_s2 <= na_s1 == nc_s1;
			na_s2   <= na_s1;
			nq_s2   <= !nb_s1 && mb_s1 != '0;
			bm_s2   <= BM_W'(mb_s1) << GUARD;
			den_s2  <= {ma_s1, 1'b0};
			sq_s3   <= sq_c;
			dv_s4   <= dv_c;
		end
	end

	always_comb begin
		four = DM_W'(mac_s2) << 2;
		bbx  = DM_W'(bb_s2);
		nd   = 1'b0;
		if (!same_s2) begin
			dmag = bbx + four;
		end else if (bbx >= four) begin
			dmag = bbx - four;
		end else begin
			dmag = four - bbx;
			nd   = 1'b1;
		end
		sq_c.na   = na_s2;
		sq_c.nq   = nq_s2;
		sq_c.bm   = bm_s2;
		sq_c.den  = den_s2;
		sq_c.rad  = RAD_W'(dmag) << (2 * GUARD);
		sq_c.rem  = '0;
		sq_c.root = '0;
		if (za_s2) begin
			sq_c.kind = KIND_DEGEN;
		end else if (nd) begin
			sq_c.kind = KIND_CPLX;
		end else if (dmag == '0) begin
			sq_c.kind = KIND_ONE;
		end else begin
			sq_c.kind = KIND_TWO;
		end
	end

	assign sq_v[0] = v_s3;
	assign sq_d[0] = sq_s3;

	for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.in_v  (sq_v[i]),
			.in_d  (sq_d[i]),
			.out_v (sq_v[i+1]),
			.out_d (sq_d[i+1])
		);
	end

	always_comb begin
		if (sq_d[SQ_W].kind == KIND_CPLX) begin
			r1.neg = sq_d[SQ_W].nq ^ sq_d[SQ_W].na;
			r1.mag = NUM_W'(sq_d[SQ_W].bm);
			r2.neg = sq_d[SQ_W].na;
			r2.mag = NUM_W'(sq_d[SQ_W].root);
		end else begin
			r1 = sm_add(sq_d[SQ_W].nq, NUM_W'(sq_d[SQ_W].bm), 1'b0,
				NUM_W'(sq_d[SQ_W].root));
			r2 = sm_add(sq_d[SQ_W].nq, NUM_W'(sq_d[SQ_W].bm), 1'b1,
				NUM_W'(sq_d[SQ_W].root));
			r1.neg = r1.neg ^ sq_d[SQ_W].na;
			r2.neg = r2.neg ^ sq_d[SQ_W].na;
		end
		dv_c.kind = sq_d[SQ_W].kind;
		dv_c.den  = sq_d[SQ_W].den;
		dv_c.lane[0].neg = r1.neg;
		dv_c.lane[0].num = NUMS_W'(r1.mag) << POST;
		dv_c.lane[0].rem = '0;
		dv_c.lane[0].quo = '0;
		dv_c.lane[1].neg = r2.neg;
		dv_c.lane[1].num = NUMS_W'(r2.mag) << POST;
		dv_c.lane[1].rem = '0;
		dv_c.lane[1].quo = '0;
	end

	assign dv_v[0] = v_s4;
	assign dv_d[0] = dv_s4;

	for (genvar i = 0; i < NUMS_W; i++) begin : g_div
		qrs_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.in_v  (dv_v[i]),
			.in_d  (dv_d[i]),
			.out_v (dv_v[i+1]),
			.out_d (dv_d[i+1])
		);
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qx[l]  = EW'(dv_d[NUMS_W].lane[l].quo);
			lim[l] = (EW'(1) << (OUT_W - 1)) - EW'(!dv_d[NUMS_W].lane[l].neg);
			cl[l]  = qx[l] > lim[l];
			qc[l]  = cl[l] ? lim[l] : qx[l];
			if (dv_d[NUMS_W].lane[l].neg) begin
				qc[l] = -qc[l];
			end
		end
		p_v    = dv_v[NUMS_W];
		p_d.kind = dv_d[NUMS_W].kind;
		if (dv_d[NUMS_W].kind == KIND_DEGEN) begin
			p_d.first  = '0;
			p_d.second = '0;
			p_d.sat    = 1'b0;
		end else begin
			p_d.first  = qc[0][OUT_W-1:0];
			p_d.second = qc[1][OUT_W-1:0];
			p_d.sat    = cl[0] || cl[1];
		end
	end

	assign take = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= p_v;
			end
		end else if (p_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_d_q <= skid_v_q ? skid_d_q : p_d;
		end
		if (!take && !skid_v_q) begin
			skid_d_q <= p_d;
		end
	end

	assign out_valid   = out_v_q;
	assign root_kind   = out_d_q.kind;
	assign root_first  = $signed(out_d_q.first);
	assign root_second = $signed(out_d_q.second);
	assign saturated   = out_d_q.sat;

endmodule

// ----- src/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [1:0]              root_kind,
	input logic signed [OUT_W-1:0] root_first,
	input logic signed [OUT_W-1:0] root_second,
	input logic                    saturated
);

	localparam logic [OUT_W-1:0] RMAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] RMIN = {1'b1, {(OUT_W-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result item dropped while stalled.");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_DEGEN |->
			root_first == '0 && root_second == '0 && !saturated)
		else $error("Degenerate item carries nonzero roots.");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_ONE |-> root_first == root_second)
		else $error("Single real root differs between outputs.");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			root_first == RMAX || root_first == RMIN ||
			root_second == RMAX || root_second == RMIN)
		else $error("Saturation flag without a clipped root.");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ----- dv/quadratic_root_solver_tb.sv -----
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient sets through a directed table and then random sets under
// several idling phases. Each result is checked field by field against a
// predictor of the roots or table entry, queued in order of acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
	import qrs_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] first;
		logic [31:0] second;
		logic        sat;
	} roots_t;

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		bit          known;
		roots_t      res;
	} coef_row_t;

	localparam int WATCHDOG = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [IN_W-1:0] coef_a = '0;
	logic signed [IN_W-1:0] coef_b = '0;
	logic signed [IN_W-1:0] coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] root_kind;
	logic signed [OUT_W-1:0] root_first;
	logic signed [OUT_W-1:0] root_second;
	logic saturated;

	roots_t pending_roots[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	quadratic_root_solver i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.root_kind(root_kind), .root_first(root_first),
		.root_second(root_second), .saturated(saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] scale_clip(logic neg, logic [63:0] mag,
			logic [63:0] den, inout logic sat);
		logic [63:0] q;
		logic [63:0] lim;
		q = (mag << POST) / den;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		if (q > lim) begin
			q = lim;
			sat = 1'b1;
		end
		return neg ? 32'(64'd0 - q) : 32'(q);
	endfunction

	function automatic void signed_sum(logic n1, logic [63:0] m1, logic n2,
			logic [63:0] m2, output logic neg, output logic [63:0] mag);
		if (n1 == n2) begin
			neg = n1;
			mag = m1 + m2;
		end else if (m1 >= m2) begin
			neg = n1;
			mag = m1 - m2;
		end else begin
			neg = n2;
			mag = m2 - m1;
		end
	endfunction

	function automatic roots_t solve_roots(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		roots_t r;
		logic na, nb, nc, nd, nn, nq;
		logic [63:0] ma, mb, mc, dmag, s, den, bm, num;
		na = a[15];
		nb = b[15];
		nc = c[15];
		ma = na ? 64'(16'(-a)) : 64'(a);
		mb = nb ? 64'(16'(-b)) : 64'(b);
		mc = nc ? 64'(16'(-c)) : 64'(c);
		r.sat = 1'b0;
		if (ma == 0) begin
			r.kind = KIND_DEGEN;
			r.first = '0;
			r.second = '0;
			return r;
		end
		signed_sum(1'b0, mb * mb, !(na != nc), (ma * mc) << 2, nd, dmag);
		if (dmag == 0)
			nd = 1'b0;
		s = int_sqrt(dmag << (2 * GUARD));
		den = ma << 1;
		bm = mb << GUARD;
		nq = !nb && mb != 0;
		if (nd) begin
			r.kind = KIND_CPLX;
			r.first = scale_clip(nq != na, bm, den, r.sat);
			r.second = scale_clip(na, s, den, r.sat);
		end else begin
			r.kind = (dmag == 0) ? KIND_ONE : KIND_TWO;
			signed_sum(nq, bm, 1'b0, s, nn, num);
			r.first = scale_clip(nn != na, num, den, r.sat);
			signed_sum(nq, bm, 1'b1, s, nn, num);
			r.second = scale_clip(nn != na, num, den, r.sat);
		end
		return r;
	endfunction

	task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_roots.push_back(solve_roots(a, b, c));
	endtask

	task automatic send_random(int n);
		logic [15:0] a, b, c;
		for (int i = 0; i < n; i++) begin
			a = 16'($urandom);
			b = 16'($urandom);
			c = 16'($urandom);
			case ($urandom_range(7, 0))
				0: a = 16'($signed(5'($urandom)));
				1: begin
					a = 16'($urandom_range(1024, 1));
					c = 16'(($signed(b) * $signed(b)) / (4 * $signed(a)));
					b = b & 16'hfffe;
				end
				2: a = '0;
				3: begin
					a = 16'($signed(3'($urandom)));
					b = 16'h8000;
				end
				default: ;
			endcase
			send_coefs(a, b, c);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		roots_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_roots.size() == 0) begin
				$error("unexpected result kind=%0d", root_kind);
				errors++;
			end else begin
				exp_r = pending_roots.pop_front();
				if (root_kind !== exp_r.kind) begin
					$error("root_kind expected %0d actual %0d", exp_r.kind, root_kind);
					errors++;
				end
				if (root_first !== exp_r.first) begin
					$error("root_first expected %h actual %h", exp_r.first, root_first);
					errors++;
				end
				if (root_second !== exp_r.second) begin
					$error("root_second expected %h actual %h", exp_r.second, root_second);
					errors++;
				end
				if (saturated !== exp_r.sat) begin
					$error("saturated expected %0d actual %0d", exp_r.sat, saturated);
					errors++;
				end
			end
		end
	end

	coef_row_t coef_table[] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1, '{KIND_DEGEN, 32'h0, 32'h0, 1'b0}},
		'{16'h0000, 16'h7fff, 16'h8000, 1, '{KIND_DEGEN, 32'h0, 32'h0, 1'b0}},
		'{16'h0100, 16'h0000, 16'h0000, 1, '{KIND_ONE, 32'h0, 32'h0, 1'b0}},
		'{16'h0100, 16'h0000, 16'hff00, 1, '{KIND_TWO, 32'h0001_0000, 32'hffff_0000, 1'b0}},
		'{16'h0100, 16'h0000, 16'h0100, 1, '{KIND_CPLX, 32'h0, 32'h0001_0000, 1'b0}},
		'{16'hff00, 16'h0000, 16'h0100, 1,
			'{KIND_TWO, 32'hffff_0000, 32'h0001_0000, 1'b0}},
		'{16'h0001, 16'h7fff, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h0001, 16'h8000, 16'h8000, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'hffff, 16'h8000, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h7fff, 16'h0001, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h8000, 16'h7fff, 16'h8000, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h8000, 16'h8000, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h0100, 16'hfe00, 16'h0100, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'hff00, 16'h0200, 16'hff00, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'hffff, 16'h0003, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h0001, 16'h0000, 16'h7fff, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'hfffe, 16'h1234, 16'h5678, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'h5555, 16'haaaa, 16'h5555, 0, '{KIND_TWO, 0, 0, 0}},
		'{16'haaaa, 16'h5555, 16'haaaa, 0, '{KIND_TWO, 0, 0, 0}}
	};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (coef_table[i]) begin
			send_coefs(coef_table[i].a, coef_table[i].b, coef_table[i].c);
			if (coef_table[i].known)
				pending_roots[pending_roots.size() - 1] = coef_table[i].res;
		end
		send_random(300);
		in_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		send_idle_pct = 53;
		send_random(350);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		send_random(350);
		send_idle_pct = 29;
		recv_stall_pct = 29;
		send_random(330);
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0 && pending_roots.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- quadratic_root_solver.f -----
src/qrs_pkg.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver.sv
src/qrs_checker.sv
dv/quadratic_root_solver_tb.sv
